>>> design/qsc_pkg.sv
// ----------------------------------------------------------------------------
// Quadrilateral shape classifier package
// Shared widths, codes, command and status types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package qsc_pkg;

    localparam int COORD_BITS   = 12;
    localparam int SIDE_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * SIDE_W;
    localparam int DOT_W        = PROD_W + 1;
    localparam int D2_W         = 2 * COORD_BITS + 1;
    localparam int DIM_W        = 13;
    localparam int MIN2_W       = 2 * DIM_W;
    localparam int D2CMP_W      = (D2_W > MIN2_W) ? D2_W : MIN2_W;

    localparam int CORDIC_W     = 44;
    localparam int NORM_BIT     = 40;
    localparam int COARSE_BIT   = 32;
    localparam int COARSE_SHIFT = 8;
    localparam int CORDIC_STEPS = 16;
    localparam int Z_W          = 24;
    localparam int ANG_W        = 15;

    localparam int SQV_W        = D2_W + 16;
    localparam int SQ_TOP       = ((SQV_W - 1) / 2) * 2;
    localparam int SQ_STEPS     = SQ_TOP / 2 + 1;
    localparam int LEN_W        = SQ_STEPS;
    localparam int SUM_W        = LEN_W + 2;
    localparam int LTOL_W       = 14;
    localparam int SCALE_W      = 17;
    localparam int CMP_W        = LEN_W + SCALE_W + 2;

    localparam int ITER_W       = $clog2(((SQ_STEPS > CORDIC_STEPS) ? SQ_STEPS
                                                                    : CORDIC_STEPS) + 1);

    localparam logic [ANG_W-1:0]   Q8_RIGHT   = ANG_W'(23040);
    localparam logic [Z_W-1:0]     Q16_RIGHT  = Z_W'(5898240);
    localparam logic [SCALE_W-1:0] LEN_SCALE  = SCALE_W'(102400);

    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 14;
    localparam int S_TDATA_W    = 128;
    localparam int M_TDATA_W    = 24;
    localparam int COUNT_W      = 16;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_KEEP_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SIDE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SIDE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_TOL   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LENGTH_TOL  = 3'd4;

    // Keep modes
    localparam logic [1:0] MODE_ANY  = 2'd0;
    localparam logic [1:0] MODE_RECT = 2'd1;

    // Reject causes
    localparam logic [2:0] CAUSE_KEPT     = 3'd0;
    localparam logic [2:0] CAUSE_SIZE     = 3'd1;
    localparam logic [2:0] CAUSE_NO_FIT   = 3'd2;
    localparam logic [2:0] CAUSE_SHORT    = 3'd3;
    localparam logic [2:0] CAUSE_PARALLEL = 3'd4;
    localparam logic [2:0] CAUSE_RIGHT    = 3'd5;
    localparam logic [2:0] CAUSE_UNEQUAL  = 3'd6;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SIZE,
        OP_SMUL,
        OP_SSUM,
        OP_AMUL,
        OP_ASUM,
        OP_AINIT,
        OP_NORM,
        OP_CORDIC,
        OP_ASTORE,
        OP_SQINIT,
        OP_SQSTEP,
        OP_SQSTORE,
        OP_LDIFF,
        OP_LMUL,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [1:0]        idx;
        logic [ITER_W-1:0] iter;
        logic [2:0]        cause;
    } dp_cmd_t;

    typedef struct packed {
        logic       size_bad;
        logic       fit_bad;
        logic       short_side;
        logic       special;
        logic       norm_done;
        logic       par_bad;
        logic       right_bad;
        logic       len_ok;
        logic       out_free;
        logic [1:0] keep_mode;
    } dp_status_t;

    // Arctangent of 2^-i in Q16 degrees.
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            4'd0:    r = Z_W'(2949120);
            4'd1:    r = Z_W'(1740967);
            4'd2:    r = Z_W'(919879);
            4'd3:    r = Z_W'(466945);
            4'd4:    r = Z_W'(234379);
            4'd5:    r = Z_W'(117304);
            4'd6:    r = Z_W'(58666);
            4'd7:    r = Z_W'(29335);
            4'd8:    r = Z_W'(14668);
            4'd9:    r = Z_W'(7334);
            4'd10:   r = Z_W'(3667);
            4'd11:   r = Z_W'(1833);
            4'd12:   r = Z_W'(917);
            4'd13:   r = Z_W'(458);
            4'd14:   r = Z_W'(229);
            default: r = Z_W'(115);
        endcase
        return r;
    endfunction

endpackage

>>> design/quadrilateral_shape_classifier_unit.sv
// ----------------------------------------------------------------------------
// Quadrilateral shape classifier
// Keeps or rejects one fitted blob at a time and counts kept blobs per frame.
// ----------------------------------------------------------------------------
// One blob enters on the s_ channel per transfer; one result leaves on the
// m_ channel for every blob. s_tuser flags the first blob of a frame, which
// clears the kept counter before that blob is counted.
// The block works on one blob at a time. A blob rejected on size or fit goes
// from the size check straight to its result; a full square check takes
// longest, set by the angle unit (normalisation of up to 12 shifts and 16
// CORDIC iterations for each of three angles) and by the square-root unit
// (21 steps for each of the four sides). The result sits in an output
// register, so the next blob is taken while an earlier result waits; if the
// receiver stalls, the block holds the next result inside, and takes no
// blobs, until the register is free. The user must write configuration
// through cfg_wr_en, cfg_addr and cfg_wr_data only while the block is idle;
// the block does not enforce this. Synchronous reset restores the register
// defaults, clears the kept counter and empties the output register.
// ----------------------------------------------------------------------------
module quadrilateral_shape_classifier_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [qsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [qsc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // box_width, box_height, fit_ok, corner0_x, corner0_y, corner1_x,
    // corner1_y, corner2_x, corner2_y, corner3_x, corner3_y, zero fill
    input  logic [qsc_pkg::S_TDATA_W-1:0]     s_tdata,
    // frame_start
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // keep, reject_cause, kept_total, zero fill
    output logic [qsc_pkg::M_TDATA_W-1:0]     m_tdata
);
    import qsc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    qsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qsc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

>>> design/qsc_ctrl.sv
// ----------------------------------------------------------------------------
// Quadrilateral shape classifier controller
// Sequences the checks of one blob and issues commands to the datapath.
// ----------------------------------------------------------------------------
module qsc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  qsc_pkg::dp_status_t status,
    output qsc_pkg::dp_cmd_t    cmd
);
    import qsc_pkg::*;

    localparam logic [1:0] LAST_SIDE  = 2'd3;
    localparam logic [1:0] ANG_FIRST  = 2'd0;
    localparam logic [1:0] ANG_SECOND = 2'd1;
    localparam logic [1:0] ANG_CORNER = 2'd2;

    typedef enum logic [18:0] {
        ST_IDLE    = 19'b0000000000000000001,
        ST_SIZE    = 19'b0000000000000000010,
        ST_SMUL    = 19'b0000000000000000100,
        ST_SSUM    = 19'b0000000000000001000,
        ST_SCHK    = 19'b0000000000000010000,
        ST_AMUL    = 19'b0000000000000100000,
        ST_ASUM    = 19'b0000000000001000000,
        ST_AINIT   = 19'b0000000000010000000,
        ST_NORM    = 19'b0000000000100000000,
        ST_CORDIC  = 19'b0000000001000000000,
        ST_ASTORE  = 19'b0000000010000000000,
        ST_ACHK    = 19'b0000000100000000000,
        ST_SQINIT  = 19'b0000001000000000000,
        ST_SQSTEP  = 19'b0000010000000000000,
        ST_SQSTORE = 19'b0000100000000000000,
        ST_LDIFF   = 19'b0001000000000000000,
        ST_LMUL    = 19'b0010000000000000000,
        ST_LCHK    = 19'b0100000000000000000,
        ST_FINISH  = 19'b1000000000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        idx_reg, idx_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [2:0]        cause_reg, cause_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            iter_reg  <= '0;
            cause_reg <= CAUSE_KEPT;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            iter_reg  <= iter_next;
            cause_reg <= cause_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        iter_next  = iter_reg;
        cause_next = cause_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = idx_reg;
        cmd.iter   = iter_reg;
        cmd.cause  = cause_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                cmd.op = OP_SIZE;
                if (status.size_bad) begin
                    cause_next = CAUSE_SIZE;
                    state_next = ST_FINISH;
                end else if (status.fit_bad) begin
                    cause_next = CAUSE_NO_FIT;
                    state_next = ST_FINISH;
                end else begin
                    idx_next   = '0;
                    state_next = ST_SMUL;
                end
            end
            ST_SMUL: begin
                cmd.op     = OP_SMUL;
                state_next = ST_SSUM;
            end
            ST_SSUM: begin
                cmd.op = OP_SSUM;
                if (idx_reg == LAST_SIDE) begin
                    state_next = ST_SCHK;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_SMUL;
                end
            end
            ST_SCHK: begin
                if (status.short_side) begin
                    cause_next = CAUSE_SHORT;
                    state_next = ST_FINISH;
                end else if (status.keep_mode == MODE_ANY) begin
                    cause_next = CAUSE_KEPT;
                    state_next = ST_FINISH;
                end else begin
                    idx_next   = ANG_FIRST;
                    state_next = ST_AMUL;
                end
            end
            ST_AMUL: begin
                cmd.op     = OP_AMUL;
                state_next = ST_ASUM;
            end
            ST_ASUM: begin
                cmd.op     = OP_ASUM;
                state_next = ST_AINIT;
            end
            ST_AINIT: begin
                cmd.op     = OP_AINIT;
                state_next = status.special ? ST_ASTORE : ST_NORM;
            end
            ST_NORM: begin
                cmd.op = OP_NORM;
                if (status.norm_done) begin
                    iter_next  = '0;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                cmd.op = OP_CORDIC;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_ASTORE;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_ASTORE: begin
                cmd.op = OP_ASTORE;
                if (idx_reg == ANG_FIRST) begin
                    idx_next   = ANG_SECOND;
                    state_next = ST_AMUL;
                end else begin
                    state_next = ST_ACHK;
                end
            end
            ST_ACHK: begin
                if (idx_reg == ANG_SECOND) begin
                    if (status.par_bad) begin
                        cause_next = CAUSE_PARALLEL;
                        state_next = ST_FINISH;
                    end else begin
                        idx_next   = ANG_CORNER;
                        state_next = ST_AMUL;
                    end
                end else if (status.right_bad) begin
                    cause_next = CAUSE_RIGHT;
                    state_next = ST_FINISH;
                end else if (status.keep_mode == MODE_RECT) begin
                    cause_next = CAUSE_KEPT;
                    state_next = ST_FINISH;
                end else begin
                    idx_next   = '0;
                    state_next = ST_SQINIT;
                end
            end
            ST_SQINIT: begin
                cmd.op     = OP_SQINIT;
                iter_next  = '0;
                state_next = ST_SQSTEP;
            end
            ST_SQSTEP: begin
                cmd.op = OP_SQSTEP;
                if (iter_reg == ITER_W'(SQ_STEPS - 1)) begin
                    state_next = ST_SQSTORE;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_SQSTORE: begin
                cmd.op = OP_SQSTORE;
                if (idx_reg == LAST_SIDE) begin
                    state_next = ST_LDIFF;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_SQINIT;
                end
            end
            ST_LDIFF: begin
                cmd.op     = OP_LDIFF;
                state_next = ST_LMUL;
            end
            ST_LMUL: begin
                cmd.op     = OP_LMUL;
                state_next = ST_LCHK;
            end
            ST_LCHK: begin
                cause_next = status.len_ok ? CAUSE_KEPT : CAUSE_UNEQUAL;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // Wait here while the previous result still sits in the output register.
                if (status.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/qsc_datapath.sv
// ----------------------------------------------------------------------------
// Quadrilateral shape classifier datapath
// Registers, products, CORDIC angle unit, square-root unit and output stage.
// ----------------------------------------------------------------------------
module qsc_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [qsc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [qsc_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic [qsc_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic                                 s_tuser,
    input  qsc_pkg::dp_cmd_t                     cmd,
    output qsc_pkg::dp_status_t                  status,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [qsc_pkg::M_TDATA_W-1:0]        m_tdata
);
    import qsc_pkg::*;

    // Configuration
    logic [1:0]        mode_reg;
    logic [DIM_W-1:0]  min_side_reg, max_side_reg, ang_tol_reg;
    logic [LTOL_W-1:0] len_tol_reg;

    // Captured blob
    logic              frame_start_reg, fit_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic signed [SIDE_W-1:0] sx_reg [4];
    logic signed [SIDE_W-1:0] sy_reg [4];

    logic [MIN2_W-1:0] min2_reg;
    logic signed [PROD_W-1:0] pxx_reg, pyy_reg, pxy_reg, pyx_reg;
    logic signed [DOT_W-1:0]  dot_reg, cross_reg;
    logic [D2_W-1:0]   d2_reg [4];
    logic              short_reg;

    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic [ANG_W-1:0]           ang_reg [3];

    logic [SQV_W-1:0]  sqv_reg, sqbit_reg;
    logic [SQV_W:0]    sqr_reg;
    logic [LEN_W-1:0]  len_reg [4];
    logic [SUM_W-1:0]  sum_reg;
    logic [LEN_W-1:0]  diff0_reg, diff1_reg;
    logic [CMP_W-1:0]  lim_reg, prd0_reg, prd1_reg;

    logic [COUNT_W-1:0] count_reg;
    logic               m_tvalid_reg, keep_out_reg;
    logic [2:0]         cause_out_reg;
    logic [COUNT_W-1:0] total_out_reg;

    // Combinational helpers
    logic [COORD_BITS-1:0]    cx [4];
    logic [COORD_BITS-1:0]    cy [4];
    logic signed [SIDE_W-1:0] ax, ay, bx, by;
    logic signed [DOT_W-1:0]  sum_dot, sum_cross;
    logic [DOT_W-1:0]         abs_dot, abs_cross;
    logic                     coarse;
    logic [3:0]               shamt;
    logic signed [CORDIC_W-1:0] xs, ys;
    logic [Z_W-1:0]           z_clamp, z_round;
    logic [ANG_W-1:0]         ang_val;
    logic [SQV_W:0]           sq_trial;
    logic [COUNT_W-1:0]       count_base, count_new;
    logic [ANG_W-1:0]         dev;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            cx[k] = COORD_BITS'(s_tdata[27 + 24*k +: 12]);
            cy[k] = COORD_BITS'(s_tdata[39 + 24*k +: 12]);
        end
    end

    // Operand pair for the shared product step
    always_comb begin
        ax = sx_reg[cmd.idx];
        ay = sy_reg[cmd.idx];
        bx = sx_reg[cmd.idx];
        by = sy_reg[cmd.idx];
        if (cmd.op == OP_AMUL) begin
            case (cmd.idx)
                2'd0: begin
                    ax = sx_reg[0]; ay = sy_reg[0]; bx = sx_reg[2]; by = sy_reg[2];
                end
                2'd1: begin
                    ax = sx_reg[1]; ay = sy_reg[1]; bx = sx_reg[3]; by = sy_reg[3];
                end
                default: begin
                    ax = -sx_reg[0]; ay = -sy_reg[0]; bx = sx_reg[1]; by = sy_reg[1];
                end
            endcase
        end
    end

    assign sum_dot   = DOT_W'(pxx_reg) + DOT_W'(pyy_reg);
    assign sum_cross = DOT_W'(pxy_reg) - DOT_W'(pyx_reg);
    assign abs_dot   = dot_reg[DOT_W-1]   ? DOT_W'(-dot_reg)   : DOT_W'(dot_reg);
    assign abs_cross = cross_reg[DOT_W-1] ? DOT_W'(-cross_reg) : DOT_W'(cross_reg);

    assign coarse = (x_reg[NORM_BIT-1:COARSE_BIT] == '0) && (y_reg[NORM_BIT-1:COARSE_BIT] == '0);
    assign shamt  = cmd.iter[3:0];
    assign xs     = x_reg >>> shamt;
    assign ys     = y_reg >>> shamt;

    always_comb begin
        if (z_reg[Z_W-1]) begin
            z_clamp = '0;
        end else if (z_reg > $signed(Q16_RIGHT)) begin
            z_clamp = Q16_RIGHT;
        end else begin
            z_clamp = z_reg;
        end
        z_round = z_clamp + Z_W'(128);
        if (cross_reg == '0) begin
            ang_val = '0;
        end else if (dot_reg == '0) begin
            ang_val = Q8_RIGHT;
        end else begin
            ang_val = ANG_W'(z_round >> 8);
        end
    end

    assign sq_trial = sqr_reg + {1'b0, sqbit_reg};

    always_comb begin
        count_base = frame_start_reg ? '0 : count_reg;
        count_new  = count_base;
        if (cmd.cause == CAUSE_KEPT && count_base != '1) begin
            count_new = count_base + 1'b1;
        end
    end

    assign dev = Q8_RIGHT - ang_reg[2];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_ANY;
            min_side_reg <= DIM_W'(10);
            max_side_reg <= DIM_W'(4096);
            ang_tol_reg  <= DIM_W'(1792);
            len_tol_reg  <= LTOL_W'(3840);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_KEEP_MODE:  mode_reg     <= cfg_wr_data[1:0];
                REG_MIN_SIDE:   min_side_reg <= cfg_wr_data[DIM_W-1:0];
                REG_MAX_SIDE:   max_side_reg <= cfg_wr_data[DIM_W-1:0];
                REG_ANGLE_TOL:  ang_tol_reg  <= cfg_wr_data[DIM_W-1:0];
                REG_LENGTH_TOL: len_tol_reg  <= cfg_wr_data[LTOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                frame_start_reg <= s_tuser;
                width_reg       <= s_tdata[12:0];
                height_reg      <= s_tdata[25:13];
                fit_reg         <= s_tdata[26];
                for (int k = 0; k < 4; k++) begin
                    sx_reg[k] <= $signed({1'b0, cx[(k + 1) % 4]}) - $signed({1'b0, cx[k]});
                    sy_reg[k] <= $signed({1'b0, cy[(k + 1) % 4]}) - $signed({1'b0, cy[k]});
                end
                short_reg <= 1'b0;
                sum_reg   <= '0;
            end
            OP_SIZE: begin
                min2_reg <= min_side_reg * min_side_reg;
            end
            OP_SMUL, OP_AMUL: begin
                pxx_reg <= ax * bx;
                pyy_reg <= ay * by;
                pxy_reg <= ax * by;
                pyx_reg <= ay * bx;
            end
            OP_SSUM: begin
                d2_reg[cmd.idx] <= D2_W'(sum_dot);
                if (D2CMP_W'(sum_dot) < D2CMP_W'(min2_reg)) begin
                    short_reg <= 1'b1;
                end
            end
            OP_ASUM: begin
                dot_reg   <= sum_dot;
                cross_reg <= sum_cross;
            end
            OP_AINIT: begin
                x_reg <= CORDIC_W'(abs_dot);
                y_reg <= CORDIC_W'(abs_cross);
                z_reg <= '0;
            end
            OP_NORM: begin
                if (!(x_reg[NORM_BIT] || y_reg[NORM_BIT])) begin
                    if (coarse) begin
                        x_reg <= x_reg <<< COARSE_SHIFT;
                        y_reg <= y_reg <<< COARSE_SHIFT;
                    end else begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end
                end
            end
            OP_CORDIC: begin
                if (!y_reg[CORDIC_W-1]) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_q16(shamt);
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_q16(shamt);
                end
            end
            OP_ASTORE: begin
                ang_reg[cmd.idx] <= ang_val;
            end
            OP_SQINIT: begin
                sqv_reg   <= {d2_reg[cmd.idx], 16'b0};
                sqr_reg   <= '0;
                sqbit_reg <= SQV_W'(1) << SQ_TOP;
            end
            OP_SQSTEP: begin
                if ({1'b0, sqv_reg} >= sq_trial) begin
                    sqv_reg <= sqv_reg - sq_trial[SQV_W-1:0];
                    sqr_reg <= (sqr_reg >> 1) + {1'b0, sqbit_reg};
                end else begin
                    sqr_reg <= sqr_reg >> 1;
                end
                sqbit_reg <= sqbit_reg >> 2;
            end
            OP_SQSTORE: begin
                len_reg[cmd.idx] <= sqr_reg[LEN_W-1:0];
                sum_reg          <= sum_reg + SUM_W'(sqr_reg[LEN_W-1:0]);
            end
            OP_LDIFF: begin
                diff0_reg <= (len_reg[0] > len_reg[1]) ? len_reg[0] - len_reg[1]
                                                       : len_reg[1] - len_reg[0];
                diff1_reg <= (len_reg[2] > len_reg[3]) ? len_reg[2] - len_reg[3]
                                                       : len_reg[3] - len_reg[2];
            end
            OP_LMUL: begin
                lim_reg  <= CMP_W'(len_tol_reg * sum_reg);
                prd0_reg <= CMP_W'(diff0_reg * LEN_SCALE);
                prd1_reg <= CMP_W'(diff1_reg * LEN_SCALE);
            end
            OP_FINISH: begin
                keep_out_reg  <= (cmd.cause == CAUSE_KEPT);
                cause_out_reg <= cmd.cause;
                total_out_reg <= count_new;
            end
            default: ;
        endcase
    end

    // Kept counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == OP_FINISH) begin
            count_reg    <= count_new;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, total_out_reg, cause_out_reg, keep_out_reg};

    assign status.size_bad   = (width_reg < min_side_reg) || (height_reg < min_side_reg) ||
                               (width_reg > max_side_reg) || (height_reg > max_side_reg);
    assign status.fit_bad    = !fit_reg;
    assign status.short_side = short_reg;
    assign status.special    = (cross_reg == '0) || (dot_reg == '0);
    assign status.norm_done  = x_reg[NORM_BIT] || y_reg[NORM_BIT];
    assign status.par_bad    = (ang_reg[0] > ANG_W'(ang_tol_reg)) ||
                               (ang_reg[1] > ANG_W'(ang_tol_reg));
    assign status.right_bad  = dev > ANG_W'(ang_tol_reg);
    assign status.len_ok     = (prd0_reg <= lim_reg) || (prd1_reg <= lim_reg);
    assign status.out_free   = !m_tvalid_reg || m_tready;
    assign status.keep_mode  = mode_reg;

endmodule

>>> design/qsc_checker.sv
// ----------------------------------------------------------------------------
// Quadrilateral shape classifier checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module qsc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [qsc_pkg::M_TDATA_W-1:0] m_tdata
);
    import qsc_pkg::*;

    // A blob is worked on alone, so a transfer is never followed at once by another.
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again in the cycle after a transfer");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // The keep flag agrees with the reject cause.
    a_keep_matches_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == CAUSE_KEPT)))
        else $error("keep flag and cause disagree");

    // Only defined causes appear.
    a_cause_defined: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] <= CAUSE_UNEQUAL))
        else $error("undefined reject cause");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind quadrilateral_shape_classifier_unit qsc_checker u_qsc_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrilateral shape classifier testbench
// Drives fitted blobs into the classifier under several register settings and
// checks every keep decision, reject cause and kept count against a predictor or, for typed rows, a written verdict.
// ----------------------------------------------------------------------------
module tb;
    import qsc_pkg::*;

    typedef struct packed {
        logic             frame_start;
        logic [12:0]      box_w;
        logic [12:0]      box_h;
        logic             fit_ok;
        logic [3:0][11:0] cx;
        logic [3:0][11:0] cy;
    } blob_t;

    typedef struct packed {
        logic        keep;
        logic [2:0]  cause;
        logic [15:0] total;
    } verdict_t;

    typedef struct {
        logic [1:0]  mode;
        logic [12:0] min_side;
        logic [12:0] max_side;
        logic [12:0] ang_tol;
        logic [13:0] len_tol;
    } setting_t;

    typedef struct {
        int       setting;
        blob_t    blob;
        bit       typed;
        verdict_t want;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    quadrilateral_shape_classifier_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor copy of the registers and the kept counter.
    logic [1:0]  p_mode;
    logic [12:0] p_min, p_max, p_atol;
    logic [13:0] p_ltol;
    logic [15:0] p_kept;

    verdict_t verdicts_due[$];
    int       mismatches = 0;
    bit       quiet = 1'b0;
    int       hold_cycles = 0;
    setting_t settings[$];
    row_t     rows[$];

    const longint atan_steps[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                     58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                     229, 115};

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Acute angle between two lines, degrees Q8, by 16 CORDIC vectoring steps.
    function automatic int acute_angle(longint ax, longint ay, longint bx, longint by);
        longint cr, dt, x, y, z, xs, ys;
        longint unsigned ux, uy;
        cr = ax * by - ay * bx;
        dt = ax * bx + ay * by;
        uy = (cr < 0) ? -cr : cr;
        ux = (dt < 0) ? -dt : dt;
        z = 0;
        if (uy == 0) return 0;
        if (ux == 0) return 23040;
        while (ux < (64'd1 << 40) && uy < (64'd1 << 40)) begin
            ux = ux << 1;
            uy = uy << 1;
        end
        x = ux;
        y = uy;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_steps[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_steps[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 5898240) z = 5898240;
        return int'((z + 128) >> 8);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [2:0] blob_cause(blob_t b);
        longint sx[4], sy[4];
        longint unsigned d2[4], len[4], sum, lim, diff, min2;
        int a1, a2, ac;
        min2 = longint'(p_min) * longint'(p_min);
        if (b.box_w < p_min || b.box_h < p_min || b.box_w > p_max || b.box_h > p_max)
            return CAUSE_SIZE;
        if (!b.fit_ok) return CAUSE_NO_FIT;
        for (int k = 0; k < 4; k++) begin
            sx[k] = longint'(b.cx[(k + 1) % 4]) - longint'(b.cx[k]);
            sy[k] = longint'(b.cy[(k + 1) % 4]) - longint'(b.cy[k]);
            d2[k] = sx[k] * sx[k] + sy[k] * sy[k];
            if (d2[k] < min2) return CAUSE_SHORT;
        end
        if (p_mode == MODE_ANY) return CAUSE_KEPT;
        a1 = acute_angle(sx[0], sy[0], sx[2], sy[2]);
        a2 = acute_angle(sx[1], sy[1], sx[3], sy[3]);
        if (a1 > int'(p_atol) || a2 > int'(p_atol)) return CAUSE_PARALLEL;
        ac = acute_angle(-sx[0], -sy[0], sx[1], sy[1]);
        if (23040 - ac > int'(p_atol)) return CAUSE_RIGHT;
        if (p_mode == MODE_RECT) return CAUSE_KEPT;
        // Modes 2 and 3 both ask for equal sides.
        sum = 0;
        for (int k = 0; k < 4; k++) begin
            len[k] = root_floor(d2[k] << 16);
            sum += len[k];
        end
        lim = longint'(p_ltol) * sum;
        diff = (len[0] > len[1]) ? len[0] - len[1] : len[1] - len[0];
        if (diff * 102400 <= lim) return CAUSE_KEPT;
        diff = (len[2] > len[3]) ? len[2] - len[3] : len[3] - len[2];
        if (diff * 102400 <= lim) return CAUSE_KEPT;
        return CAUSE_UNEQUAL;
    endfunction

    function automatic verdict_t classify_blob(blob_t b);
        verdict_t v;
        if (b.frame_start) p_kept = '0;
        v.cause = blob_cause(b);
        if (v.cause == CAUSE_KEPT && p_kept != 16'hFFFF) p_kept++;
        v.keep = (v.cause == CAUSE_KEPT);
        v.total = p_kept;
        return v;
    endfunction

    function automatic blob_t quad(logic fs, int w, int h, logic fit, int x0, int y0,
                                   int x1, int y1, int x2, int y2, int x3, int y3);
        blob_t b;
        b.frame_start = fs;
        b.box_w = 13'(w); b.box_h = 13'(h); b.fit_ok = fit;
        b.cx[0] = 12'(x0); b.cy[0] = 12'(y0); b.cx[1] = 12'(x1); b.cy[1] = 12'(y1);
        b.cx[2] = 12'(x2); b.cy[2] = 12'(y2); b.cx[3] = 12'(x3); b.cy[3] = 12'(y3);
        return b;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    // Mostly near-rectangles with random jitter, so blobs reach the angle and
    // length checks; the rest is noise, with box sizes from 1 to 4096.
    function automatic blob_t random_blob();
        blob_t b;
        logic [127:0] noise;
        int x[4], y[4], ax, ay, bx, by, sc, jit, lo, hi;
        noise = {$urandom, $urandom, $urandom, $urandom};
        b = blob_t'(noise[$bits(blob_t)-1:0]);
        b.frame_start = ($urandom_range(0, 99) < 5);
        if ($urandom_range(0, 99) < 30) begin
            b.box_w = 13'($urandom_range(1, 4096));
            b.box_h = 13'($urandom_range(1, 4096));
            b.fit_ok = $urandom_range(0, 99) < 80;
            return b;
        end
        ax = int'($urandom_range(0, 1600)) - 800;
        ay = int'($urandom_range(0, 1600)) - 800;
        sc = ($urandom_range(0, 1)) ? 8 : int'($urandom_range(2, 16));
        bx = -ay * sc / 8;
        by = ax * sc / 8;
        case ($urandom_range(0, 3))
            0: jit = 0;
            1: jit = 1;
            2: jit = 4;
            default: jit = 40;
        endcase
        x[0] = int'($urandom_range(900, 3100)); y[0] = int'($urandom_range(900, 3100));
        x[1] = x[0] + ax; y[1] = y[0] + ay;
        x[2] = x[1] + bx; y[2] = y[1] + by;
        x[3] = x[0] + bx; y[3] = y[0] + by;
        for (int k = 0; k < 4; k++) begin
            b.cx[k] = 12'(clamp_coord(x[k] + int'($urandom_range(0, 2 * jit)) - jit));
            b.cy[k] = 12'(clamp_coord(y[k] + int'($urandom_range(0, 2 * jit)) - jit));
        end
        lo = 4095; hi = 0;
        for (int k = 0; k < 4; k++) begin
            if (int'(b.cx[k]) < lo) lo = int'(b.cx[k]);
            if (int'(b.cx[k]) > hi) hi = int'(b.cx[k]);
        end
        b.box_w = 13'(hi - lo + 1);
        lo = 4095; hi = 0;
        for (int k = 0; k < 4; k++) begin
            if (int'(b.cy[k]) < lo) lo = int'(b.cy[k]);
            if (int'(b.cy[k]) > hi) hi = int'(b.cy[k]);
        end
        b.box_h = 13'(hi - lo + 1);
        if ($urandom_range(0, 99) < 10) b.box_w = 13'($urandom_range(1, 4096));
        b.fit_ok = $urandom_range(0, 99) < 95;
        return b;
    endfunction

    task automatic write_settings(setting_t st);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_KEEP_MODE;  cfg_wr_data <= CFG_DATA_W'(st.mode);     @(posedge aclk);
        cfg_addr <= REG_MIN_SIDE;   cfg_wr_data <= CFG_DATA_W'(st.min_side); @(posedge aclk);
        cfg_addr <= REG_MAX_SIDE;   cfg_wr_data <= CFG_DATA_W'(st.max_side); @(posedge aclk);
        cfg_addr <= REG_ANGLE_TOL;  cfg_wr_data <= CFG_DATA_W'(st.ang_tol);  @(posedge aclk);
        cfg_addr <= REG_LENGTH_TOL; cfg_wr_data <= CFG_DATA_W'(st.len_tol);  @(posedge aclk);
        cfg_wr_en <= 1'b0;
        p_mode = st.mode; p_min = st.min_side; p_max = st.max_side;
        p_atol = st.ang_tol; p_ltol = st.len_tol;
    endtask

    task automatic drain();
        while (verdicts_due.size() != 0) @(posedge aclk);
        // Leave the block a little time after its last result.
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_blob(blob_t b, bit typed, verdict_t want);
        verdict_t v;
        s_tvalid <= 1'b1;
        s_tuser <= b.frame_start;
        s_tdata <= {5'b0, b.cy[3], b.cx[3], b.cy[2], b.cx[2], b.cy[1], b.cx[1],
                    b.cy[0], b.cx[0], b.fit_ok, b.box_h, b.box_w};
        do @(posedge aclk); while (!s_tready);
        v = classify_blob(b);
        verdicts_due.push_back(typed ? want : v);
        if (!quiet && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Result side: random back-pressure, plus long hold-offs on request.
    initial begin
        verdict_t got, want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[3:1], m_tdata[19:4]};
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.keep !== want.keep || got.cause !== want.cause ||
                        got.total !== want.total || m_tdata[23:20] !== 4'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected keep %0d cause %0d total %0d, got %0h",
                                     want.keep, want.cause, want.total, m_tdata);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        int idle_run;
        idle_run = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
            else idle_run++;
            if (idle_run >= 4000) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        setting_t st;
        row_t r;
        verdict_t none;
        int cur;
        none = '0;
        // Setting 0 is the reset state; no write goes out for it.
        settings.push_back('{2'd0, 13'd10, 13'd4096, 13'd1792, 14'd3840});
        settings.push_back('{2'd2, 13'd0, 13'd4096, 13'd5120, 14'd0});
        settings.push_back('{2'd3, 13'd5, 13'd5, 13'd0, 14'd12800});
        settings.push_back('{2'd1, 13'd0, 13'd4096, 13'd0, 14'd0});

        // Typed rows: reject causes and counts under the reset registers.
        r.typed = 1;
        r.setting = 0;
        r.blob = quad(1, 9, 50, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        r.want = '{0, CAUSE_SIZE, 0}; rows.push_back(r);
        r.blob = quad(0, 50, 4097, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        r.want = '{0, CAUSE_SIZE, 0}; rows.push_back(r);
        r.blob = quad(0, 100, 100, 0, 100, 100, 200, 100, 200, 200, 100, 200);
        r.want = '{0, CAUSE_NO_FIT, 0}; rows.push_back(r);
        r.blob = quad(0, 100, 100, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        r.want = '{0, CAUSE_SHORT, 0}; rows.push_back(r);
        r.blob = quad(0, 100, 100, 1, 100, 100, 200, 100, 200, 200, 100, 200);
        r.want = '{1, CAUSE_KEPT, 1}; rows.push_back(r);
        r.blob = quad(0, 4096, 4096, 1, 0, 0, 4095, 0, 4095, 4095, 0, 4095);
        r.want = '{1, CAUSE_KEPT, 2}; rows.push_back(r);
        r.blob = quad(0, 10, 10, 1, 4095, 4095, 4085, 4095, 4085, 4085, 4095, 4085);
        r.want = '{1, CAUSE_KEPT, 3}; rows.push_back(r);
        r.blob = quad(1, 4096, 4096, 1, 0, 0, 9, 0, 9, 9, 0, 9);
        r.want = '{0, CAUSE_SHORT, 0}; rows.push_back(r);
        // Predicted rows: zero-length sides, collinear sides, exact right
        // angles, slanted and unequal shapes, and the spare mode value.
        r.typed = 0;
        r.want = none;
        r.setting = 1;
        r.blob = quad(1, 50, 50, 1, 7, 7, 7, 7, 7, 7, 7, 7);                   rows.push_back(r);
        r.blob = quad(0, 50, 50, 1, 0, 0, 100, 0, 200, 0, 300, 0);             rows.push_back(r);
        r.blob = quad(0, 50, 50, 1, 100, 100, 400, 100, 400, 200, 100, 200);   rows.push_back(r);
        r.blob = quad(0, 50, 50, 1, 100, 100, 300, 100, 350, 300, 150, 300);   rows.push_back(r);
        r.blob = quad(0, 50, 50, 1, 100, 100, 300, 100, 250, 300, 150, 300);   rows.push_back(r);
        r.setting = 2;
        r.blob = quad(1, 5, 5, 1, 0, 0, 4095, 0, 4095, 4095, 0, 4095);         rows.push_back(r);
        r.blob = quad(0, 5, 5, 1, 10, 10, 20, 10, 20, 30, 10, 30);             rows.push_back(r);
        r.blob = quad(0, 5, 5, 1, 10, 10, 20, 11, 19, 21, 9, 20);              rows.push_back(r);
        r.setting = 3;
        r.blob = quad(0, 100, 100, 1, 100, 100, 200, 100, 200, 200, 100, 200); rows.push_back(r);
        r.blob = quad(0, 100, 100, 1, 100, 100, 200, 100, 201, 200, 100, 200); rows.push_back(r);
        r.blob = quad(0, 100, 100, 1, 0, 0, 0, 0, 0, 0, 0, 0);                 rows.push_back(r);

        p_mode = 2'd0; p_min = 13'd10; p_max = 13'd4096; p_atol = 13'd1792;
        p_ltol = 14'd3840; p_kept = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cur = 0;
        foreach (rows[i]) begin
            if (rows[i].setting != cur) begin
                s_tvalid <= 1'b0;
                drain();
                cur = rows[i].setting;
                write_settings(settings[cur]);
            end
            send_blob(rows[i].blob, rows[i].typed, rows[i].want);
        end

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 8; ph++) begin
            s_tvalid <= 1'b0;
            drain();
            case (ph)
                0: st = '{2'd0, 13'd10, 13'd4096, 13'd1792, 14'd3840};
                1: st = '{2'd1, 13'd5, 13'd4096, 13'd1792, 14'd3840};
                2: st = '{2'd2, 13'd5, 13'd4096, 13'd5120, 14'd12800};
                3: st = '{2'd2, 13'd20, 13'd3000, 13'd600, 14'd800};
                4: st = '{2'd1, 13'd4096, 13'd4096, 13'd0, 14'd0};
                5: st = '{2'd3, 13'd5, 13'd2500, 13'd300, 14'd200};
                6: st = '{2'd1, 13'd30, 13'd1500, 13'd5120, 14'd12800};
                default: st = '{2'd2, 13'd8, 13'd4096, 13'd1000, 14'd2000};
            endcase
            write_settings(st);
            quiet = (ph == 2);
            if (ph == 3) hold_cycles = 300;
            repeat (85) send_blob(random_blob(), 0, none);
        end
        quiet = 1'b0;
        repeat (20) send_blob(random_blob(), 0, none);

        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
